>>> design/sha224_pkg.sv
// ----------------------------------------------------------------------------
// sha224_pkg
// Shared types, constants and round functions of the SHA-224 engine.
// ----------------------------------------------------------------------------
package sha224_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [7:0] data;
		logic       byte_valid;
		logic       last;
	} item_t;

	typedef logic [31:0] word_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam word_t IV [8] = '{
		32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
		32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
	};

	localparam word_t K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// back end states
	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_RND  = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t bsig0(input word_t x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t ssig0(input word_t x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t ssig1(input word_t x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

>>> design/sha224_front.sv
// ----------------------------------------------------------------------------
// sha224_front
// Input side: accepts words, drops empty ones, queues the rest for the core.
// ----------------------------------------------------------------------------
module sha224_front import sha224_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       byte_valid,
	input  logic       last,
	output logic       q_valid,
	output item_t      q_item,
	input  logic       q_pop
);

	item_t            mem_q [QDEPTH];
	logic [QAW-1:0]   wptr_q, rptr_q;
	logic [QAW:0]     cnt_q;
	logic             push;

	assign in_stall = (cnt_q == (QAW+1)'(QDEPTH));
	// words with neither a byte nor an end mark do nothing
	assign push     = in_valid && !in_stall && (byte_valid || last);
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= '{data: data_byte, byte_valid: byte_valid, last: last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (q_pop) rptr_q <= rptr_q + 1'b1;
			unique case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> design/sha224_core.sv
// ----------------------------------------------------------------------------
// sha224_core
// Back end: block packing, padding, 64-round compression, digest output.
// ----------------------------------------------------------------------------
module sha224_core import sha224_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	logic [2:0]  state_q;
	word_t       blk_q [16];
	word_t       cv_q  [8];
	word_t       v_q   [8];
	logic [5:0]  fill_q;
	logic [63:0] bitlen_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        pad_q, second_q, fin_q;

	word_t       pad_blk [16];
	word_t       t1, t2, wnew;
	logic        wrap;

	assign q_pop = (state_q == ST_LOAD) && q_valid;
	assign wrap  = (fill_q == 6'd63);

	// padded block built from the partial one
	always_comb begin
		for (int w = 0; w < 16; w++) begin
			for (int j = 0; j < 4; j++) begin
				if (second_q || (6'(w*4+j) > fill_q)) begin
					pad_blk[w][31-8*j -: 8] = 8'h00;
				end else if (6'(w*4+j) == fill_q) begin
					pad_blk[w][31-8*j -: 8] = PAD_BYTE;
				end else begin
					pad_blk[w][31-8*j -: 8] = blk_q[w][31-8*j -: 8];
				end
			end
		end
		if (second_q || fill_q <= 6'd55) begin
			pad_blk[14] = bitlen_q[63:32];
			pad_blk[15] = bitlen_q[31:0];
		end
	end

	assign t1   = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ K[rnd_q] + blk_q[0];
	assign t2   = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign wnew = ssig1(blk_q[14]) + blk_q[9] + ssig0(blk_q[1]) + blk_q[0];

	assign out_valid   = (state_q == ST_OUT);
	assign digest_word = cv_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd6);

	// data path
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: begin
				if (q_pop && q_item.byte_valid) begin
					blk_q[fill_q[5:2]][31-8*fill_q[1:0] -: 8] <= q_item.data;
				end
				if (q_pop && q_item.byte_valid && wrap) v_q <= cv_q;
			end
			ST_PAD: begin
				blk_q <= pad_blk;
				v_q   <= cv_q;
			end
			ST_RND: begin
				// window of the message schedule slides one word a round
				for (int i = 0; i < 15; i++) blk_q[i] <= blk_q[i+1];
				blk_q[15] <= wnew;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			default: ;
		endcase
	end

	// control and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			cv_q     <= IV;
			fill_q   <= '0;
			bitlen_q <= '0;
			rnd_q    <= '0;
			idx_q    <= '0;
			pad_q    <= 1'b0;
			second_q <= 1'b0;
			fin_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (q_pop) begin
						second_q <= 1'b0;
						fin_q    <= 1'b0;
						if (q_item.byte_valid) begin
							fill_q   <= fill_q + 1'b1;
							bitlen_q <= bitlen_q + 64'd8;
						end
						if (q_item.byte_valid && wrap) begin
							pad_q   <= q_item.last;
							rnd_q   <= '0;
							state_q <= ST_RND;
						end else if (q_item.last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					rnd_q   <= '0;
					state_q <= ST_RND;
					if (!second_q && fill_q > 6'd55) begin
						// length does not fit: one more block follows
						pad_q    <= 1'b1;
						second_q <= 1'b1;
						fin_q    <= 1'b0;
					end else begin
						pad_q <= 1'b0;
						fin_q <= 1'b1;
					end
				end
				ST_RND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] + v_q[i];
					priority if (fin_q) begin
						idx_q   <= '0;
						state_q <= ST_OUT;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == 3'd6) begin
							cv_q     <= IV;
							fill_q   <= '0;
							bitlen_q <= '0;
							second_q <= 1'b0;
							fin_q    <= 1'b0;
							pad_q    <= 1'b0;
							state_q  <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

>>> design/sha224_hash.sv
// ----------------------------------------------------------------------------
// sha224_hash
// SHA-224 engine, one message byte per input word, digest as seven words.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): data_byte with byte_valid, and last
// to end a message. A word with last and no byte ends the message with the
// bytes already given, so an empty message is a single such word.
// Output channel (out_valid / out_stall): seven digest words, word_index 0
// (most significant) to 6, last_word set on the seventh.
// A four-entry queue sits between the input side and the core, so input is
// taken while the core compresses or the digest waits.
// Throughput: one byte per cycle into the block while the queue holds
// data, then per full block 64 rounds, one per cycle, and an add step.
// After the word with last is accepted, padding, the rounds and the add
// step run, once more for a second block when the length spills into it,
// before the first digest word appears.
// A stalled output holds its word; the core waits, the queue fills, then
// in_stall rises. Reset clears the queue, length and fill count and loads
// the initial hash values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha224_hash import sha224_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	logic  q_valid, q_pop;
	item_t q_item;

	sha224_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .byte_valid(byte_valid), .last(last),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	sha224_core u_core (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

endmodule
